FILE: rtl/izvd_pkg.sv
// Shared types and constants for the IMU zero-velocity detector.
// No dependencies; every other file of the block but izvd_ram imports this package.
package izvd_pkg;

  localparam int ACCEL_W = 20;
  localparam int GYRO_W  = 18;
  localparam int NORM_W  = 20;
  localparam int SQ_W    = 40;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 16;
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  typedef enum logic [2:0] {
    REG_GRAVITY_NORM     = 3'd0,
    REG_ACCEL_DEV_LIMIT  = 3'd1,
    REG_GYRO_RATE_LIMIT  = 3'd2,
    REG_GYRO_VAR_LIMIT   = 3'd3,
    REG_ACCEL_VAR_LIMIT  = 3'd4,
    REG_AVAILABLE_PERIOD = 3'd5
  } reg_e;

  localparam logic [15:0] RST_GRAVITY_NORM     = 16'd10042;
  localparam logic [31:0] RST_ACCEL_DEV_LIMIT  = 32'd1132462080;
  localparam logic [16:0] RST_GYRO_RATE_LIMIT  = 17'd24576;
  localparam logic [33:0] RST_GYRO_VAR_LIMIT   = 34'd1509949;
  localparam logic [39:0] RST_ACCEL_VAR_LIMIT  = 40'd26214400;
  localparam logic [7:0]  RST_AVAILABLE_PERIOD = 8'd5;

  typedef struct packed {
    logic [15:0] gravity_norm;
    logic [31:0] accel_dev_limit;
    logic [16:0] gyro_rate_limit;
    logic [33:0] gyro_var_limit;
    logic [39:0] accel_var_limit;
    logic [7:0]  available_period;
  } cfg_t;

  typedef struct packed {
    logic [NORM_W-1:0]        norm;
    logic signed [GYRO_W-1:0] gyro;
  } sample_t;

  typedef struct packed {
    logic             window_full;
    logic             stationary;
    logic             zupt_available;
    logic [CNT_W-1:0] still_count;
  } result_t;

endpackage

FILE: rtl/izvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module izvd_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/izvd_front.sv
// Front end: accepts IMU samples, forms the squared acceleration magnitude
// and its integer root one bit pair per cycle. Depends on izvd_pkg.
module izvd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_y_i,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_z_i,
  input  logic signed [izvd_pkg::GYRO_W-1:0]  gyro_y_i,
  output logic                            push_o,
  output izvd_pkg::sample_t               push_data_o,
  input  logic                            full_i
);
  import izvd_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_PUSH} fstate_e;

  fstate_e                  state_q;
  logic [ACCEL_W-1:0]       mag_q [3];
  logic signed [GYRO_W-1:0] gy_q;
  logic [1:0]               step_q;
  logic [4:0]               iter_q;
  logic [SQ_W-1:0]          p_q;
  logic [SQ_W-1:0]          sum_q;
  logic [SQ_W-1:0]          rad_q;
  logic [NORM_W+1:0]        rem_q;
  logic [NORM_W-1:0]        root_q;

  logic [ACCEL_W-1:0] mag_sel;
  logic [NORM_W+1:0]  rem_t;
  logic [NORM_W+1:0]  trial;
  logic               accept;

  function automatic logic [ACCEL_W-1:0] mag(input logic signed [ACCEL_W-1:0] v);
    logic signed [ACCEL_W-1:0] n;
    n = -v;
    return v[ACCEL_W-1] ? ACCEL_W'(n) : ACCEL_W'(v);
  endfunction

  assign in_stall_o  = (state_q != F_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = '{norm: root_q, gyro: gy_q};

  always_comb begin
    case (step_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      2'd2:    mag_sel = mag_q[2];
      default: mag_sel = '0;
    endcase
  end

  assign rem_t = {rem_q[NORM_W-1:0], rad_q[SQ_W-1 -: 2]};
  assign trial = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mag_q   <= '{default: '0};
      gy_q    <= '0;
      step_q  <= '0;
      iter_q  <= '0;
      p_q     <= '0;
      sum_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            mag_q[0] <= mag(accel_x_i);
            mag_q[1] <= mag(accel_y_i);
            mag_q[2] <= mag(accel_z_i);
            gy_q     <= gyro_y_i;
            step_q   <= '0;
            sum_q    <= '0;
            state_q  <= F_SQ;
          end
        end
        F_SQ: begin
          // square one axis, fold in the previous square
          p_q <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
          if (step_q != 2'd0) begin
            sum_q <= sum_q + p_q;
          end
          if (step_q == 2'd3) begin
            rad_q   <= sum_q + p_q;
            rem_q   <= '0;
            root_q  <= '0;
            iter_q  <= '0;
            state_q <= F_ROOT;
          end else begin
            step_q <= step_q + 2'd1;
          end
        end
        F_ROOT: begin
          if (rem_t >= trial) begin
            rem_q  <= rem_t - trial;
            root_q <= {root_q[NORM_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem_t;
            root_q <= {root_q[NORM_W-2:0], 1'b0};
          end
          rad_q <= {rad_q[SQ_W-3:0], 2'b00};
          if (iter_q == 5'(NORM_W - 1)) begin
            state_q <= F_PUSH;
          end else begin
            iter_q <= iter_q + 5'd1;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/izvd_fifo.sv
// Two-entry sample queue between front and back end.
// Depends on izvd_pkg for the sample type.
module izvd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  izvd_pkg::sample_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output izvd_pkg::sample_t data_o,
  output logic              empty_o
);
  import izvd_pkg::*;

  sample_t    mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q  <= '{default: '0};
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        mem_q[wptr_q] <= data_i;
        wptr_q        <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/izvd_back.sv
// Back end: window memory, running sums, stillness tests on one shared
// 32x32 multiplier, still counter and availability flag.
// Depends on izvd_pkg and izvd_ram.
module izvd_back #(
  parameter int WIN_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  izvd_pkg::cfg_t    cfg_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  izvd_pkg::sample_t sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output izvd_pkg::result_t result_o
);
  import izvd_pkg::*;

  localparam int IDX_W  = $clog2(WIN_LEN);
  localparam int FILL_W = $clog2(WIN_LEN + 1);
  localparam int NS_W   = NORM_W + FILL_W;
  localparam int RS_W   = GYRO_W + FILL_W;
  localparam int RAM_W  = NORM_W + GYRO_W;
  localparam logic [31:0]      N32       = 32'(WIN_LEN);
  localparam logic [31:0]      NN32      = 32'(WIN_LEN * WIN_LEN);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_LEN);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WIN_LEN - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_READ, B_LOAD, B_MUL, B_ACC, B_COMMIT, B_TEST, B_MOD, B_DONE
  } bstate_e;

  typedef enum logic [2:0] {
    ACC_NSS, ACC_RSS, ACC_NV, ACC_RV, ACC_DEV, ACC_LDEV, ACC_LRV, ACC_LNV
  } acc_e;

  typedef enum logic [4:0] {
    OP_OLD_NORM, OP_OLD_RATE, OP_NEW_NORM, OP_NEW_RATE,
    OP_NV_LO, OP_NV_HI, OP_NV_SUM,
    OP_RV_LO, OP_RV_HI, OP_RV_SUM,
    OP_GG, OP_DEV_GG, OP_DEV_CROSS, OP_LDEV,
    OP_LRV_LO, OP_LRV_HI, OP_LNV_LO, OP_LNV_HI
  } op_e;

  typedef struct packed {
    acc_e dest;
    logic hi;
    logic sub;
    logic dbl;
    logic repl;
  } op_ctl_t;

  bstate_e                  state_q;
  op_e                      op_q;
  op_ctl_t                  ctl_q;
  logic [31:0]              a_q;
  logic [31:0]              b_q;
  logic [ACC_W-1:0]         p_q;
  logic [ACC_W-1:0]         acc_q [8];
  logic [NS_W-1:0]          ns_q;
  logic signed [RS_W-1:0]   rs_q;
  logic [FILL_W-1:0]        fill_q;
  logic [IDX_W-1:0]         slot_q;
  logic [NORM_W-1:0]        norm_q;
  logic signed [GYRO_W-1:0] gy_q;
  logic [NORM_W-1:0]        old_norm_q;
  logic signed [GYRO_W-1:0] old_rate_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     flag_q;
  logic                     stat_q;
  logic                     wf_q;
  logic [8:0]               rem_q;
  logic [3:0]               bit_q;
  logic                     out_valid_q;
  result_t                  res_q;

  logic [31:0]        a_d;
  logic [31:0]        b_d;
  op_ctl_t            ctl_d;
  logic [GYRO_W-1:0]  old_abs;
  logic [GYRO_W-1:0]  gy_abs;
  logic [RS_W-1:0]    rs_abs;
  logic [ACC_W-1:0]   term;
  logic [ACC_W-1:0]   acc_sel;
  logic [FILL_W-1:0]  fill_inc;
  logic [8:0]         rem_t;
  logic [8:0]         rem_n;
  logic               still;
  logic [RAM_W-1:0]   rdata;
  logic               ram_we;

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign ram_we      = (state_q == B_COMMIT);

  izvd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WIN_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({norm_q, gy_q}),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  always_comb begin
    old_abs  = old_rate_q[GYRO_W-1] ? GYRO_W'(-old_rate_q) : GYRO_W'(old_rate_q);
    gy_abs   = gy_q[GYRO_W-1] ? GYRO_W'(-gy_q) : GYRO_W'(gy_q);
    rs_abs   = rs_q[RS_W-1] ? RS_W'(-rs_q) : RS_W'(rs_q);
    fill_inc = fill_q + FILL_W'(1);
    acc_sel  = acc_q[ctl_q.dest];
    term     = ctl_q.hi ? {p_q[31:0], 32'h0} : p_q;
    if (ctl_q.dbl) begin
      term = {term[ACC_W-2:0], 1'b0};
    end
    rem_t = {rem_q[7:0], cnt_q[bit_q]};
    rem_n = (rem_t >= {1'b0, cfg_i.available_period}) ?
            rem_t - {1'b0, cfg_i.available_period} : rem_t;
    still = (acc_q[ACC_DEV] < acc_q[ACC_LDEV])
         && (gy_abs < {1'b0, cfg_i.gyro_rate_limit})
         && (acc_q[ACC_RV] < acc_q[ACC_LRV])
         && (acc_q[ACC_NV] < acc_q[ACC_LNV]);
  end

  // micro-op table: operands and accumulation of each multiply
  always_comb begin
    a_d       = '0;
    b_d       = '0;
    ctl_d.dest = ACC_NSS;
    ctl_d.hi   = 1'b0;
    ctl_d.sub  = 1'b0;
    ctl_d.dbl  = 1'b0;
    ctl_d.repl = 1'b0;
    case (op_q)
      OP_OLD_NORM: begin
        a_d = 32'(old_norm_q); b_d = 32'(old_norm_q); ctl_d.sub = 1'b1;
      end
      OP_OLD_RATE: begin
        a_d = 32'(old_abs); b_d = 32'(old_abs);
        ctl_d.dest = ACC_RSS; ctl_d.sub = 1'b1;
      end
      OP_NEW_NORM: begin
        a_d = 32'(norm_q); b_d = 32'(norm_q);
      end
      OP_NEW_RATE: begin
        a_d = 32'(gy_abs); b_d = 32'(gy_abs); ctl_d.dest = ACC_RSS;
      end
      OP_NV_LO: begin
        a_d = acc_q[ACC_NSS][31:0]; b_d = N32; ctl_d.dest = ACC_NV;
      end
      OP_NV_HI: begin
        a_d = acc_q[ACC_NSS][63:32]; b_d = N32; ctl_d.dest = ACC_NV; ctl_d.hi = 1'b1;
      end
      OP_NV_SUM: begin
        a_d = 32'(ns_q); b_d = 32'(ns_q); ctl_d.dest = ACC_NV; ctl_d.sub = 1'b1;
      end
      OP_RV_LO: begin
        a_d = acc_q[ACC_RSS][31:0]; b_d = N32; ctl_d.dest = ACC_RV;
      end
      OP_RV_HI: begin
        a_d = acc_q[ACC_RSS][63:32]; b_d = N32; ctl_d.dest = ACC_RV; ctl_d.hi = 1'b1;
      end
      OP_RV_SUM: begin
        a_d = 32'(rs_abs); b_d = 32'(rs_abs); ctl_d.dest = ACC_RV; ctl_d.sub = 1'b1;
      end
      OP_GG: begin
        a_d = 32'(cfg_i.gravity_norm); b_d = 32'(cfg_i.gravity_norm);
        ctl_d.dest = ACC_LDEV; ctl_d.repl = 1'b1;
      end
      OP_DEV_GG: begin
        a_d = acc_q[ACC_LDEV][31:0]; b_d = N32; ctl_d.dest = ACC_DEV;
      end
      OP_DEV_CROSS: begin
        a_d = 32'(cfg_i.gravity_norm); b_d = 32'(ns_q);
        ctl_d.dest = ACC_DEV; ctl_d.sub = 1'b1; ctl_d.dbl = 1'b1;
      end
      OP_LDEV: begin
        a_d = cfg_i.accel_dev_limit; b_d = N32;
        ctl_d.dest = ACC_LDEV; ctl_d.repl = 1'b1;
      end
      OP_LRV_LO: begin
        a_d = cfg_i.gyro_var_limit[31:0]; b_d = NN32;
        ctl_d.dest = ACC_LRV; ctl_d.repl = 1'b1;
      end
      OP_LRV_HI: begin
        a_d = 32'(cfg_i.gyro_var_limit[33:32]); b_d = NN32;
        ctl_d.dest = ACC_LRV; ctl_d.hi = 1'b1;
      end
      OP_LNV_LO: begin
        a_d = cfg_i.accel_var_limit[31:0]; b_d = NN32;
        ctl_d.dest = ACC_LNV; ctl_d.repl = 1'b1;
      end
      OP_LNV_HI: begin
        a_d = 32'(cfg_i.accel_var_limit[39:32]); b_d = NN32;
        ctl_d.dest = ACC_LNV; ctl_d.hi = 1'b1;
      end
      default: begin
        a_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= OP_OLD_NORM;
      ctl_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      p_q         <= '0;
      acc_q       <= '{default: '0};
      ns_q        <= '0;
      rs_q        <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      norm_q      <= '0;
      gy_q        <= '0;
      old_norm_q  <= '0;
      old_rate_q  <= '0;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      stat_q      <= 1'b0;
      wf_q        <= 1'b0;
      rem_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (state_q == B_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            norm_q  <= sample_i.norm;
            gy_q    <= sample_i.gyro;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          // oldest entry leaves the sums only once the window is full
          if (fill_q == FILL_MAX) begin
            old_norm_q <= rdata[RAM_W-1 -: NORM_W];
            old_rate_q <= rdata[GYRO_W-1:0];
          end else begin
            old_norm_q <= '0;
            old_rate_q <= '0;
          end
          op_q    <= OP_OLD_NORM;
          state_q <= B_LOAD;
        end
        B_LOAD: begin
          a_q     <= a_d;
          b_q     <= b_d;
          ctl_q   <= ctl_d;
          state_q <= B_MUL;
        end
        B_MUL: begin
          p_q     <= ACC_W'(a_q) * ACC_W'(b_q);
          state_q <= B_ACC;
        end
        B_ACC: begin
          if (ctl_q.repl) begin
            acc_q[ctl_q.dest] <= term;
          end else if (ctl_q.sub) begin
            acc_q[ctl_q.dest] <= acc_sel - term;
          end else begin
            acc_q[ctl_q.dest] <= acc_sel + term;
          end
          if (op_q == OP_NEW_RATE) begin
            state_q <= B_COMMIT;
          end else if (op_q == OP_LNV_HI) begin
            state_q <= B_TEST;
          end else begin
            op_q    <= op_e'(op_q + 5'd1);
            state_q <= B_LOAD;
          end
        end
        B_COMMIT: begin
          ns_q   <= ns_q - NS_W'(old_norm_q) + NS_W'(norm_q);
          rs_q   <= rs_q - RS_W'(old_rate_q) + RS_W'(gy_q);
          slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + IDX_W'(1);
          if (fill_q != FILL_MAX) begin
            fill_q <= fill_inc;
          end
          if (fill_q != FILL_MAX && fill_inc != FILL_MAX) begin
            wf_q    <= 1'b0;
            stat_q  <= 1'b0;
            state_q <= B_DONE;
          end else begin
            acc_q[ACC_NV]  <= '0;
            acc_q[ACC_RV]  <= '0;
            acc_q[ACC_DEV] <= acc_q[ACC_NSS];
            op_q           <= OP_NV_LO;
            state_q        <= B_LOAD;
          end
        end
        B_TEST: begin
          wf_q   <= 1'b1;
          stat_q <= still;
          if (still) begin
            if (cnt_q != {CNT_W{1'b1}}) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            rem_q   <= '0;
            bit_q   <= 4'(CNT_W - 1);
            state_q <= B_MOD;
          end else begin
            cnt_q   <= '0;
            flag_q  <= 1'b0;
            state_q <= B_DONE;
          end
        end
        B_MOD: begin
          // restoring remainder of the count by the period, one bit a cycle
          rem_q <= rem_n;
          if (bit_q == 4'd0) begin
            if (cfg_i.available_period != 8'd0 && rem_n == 9'd0) begin
              flag_q <= 1'b1;
            end
            state_q <= B_DONE;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        B_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            res_q       <= '{window_full: wf_q, stationary: stat_q,
                             zupt_available: flag_q, still_count: cnt_q};
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/imu_zero_velocity_detector_core.sv
// The front end forms 3 squares, then a 20-step root; the back end runs 18
// multiplies on one shared multiplier once the window is full, plus a 16-step
// period remainder for a stationary sample. Sustained rate is front end bound
// while the window fills, then one request per back-end pass.
// Reset clears all sums, counters, flags and registers to their reset values;
// window memory holds no reset state and its read data is only used after being written.
module imu_zero_velocity_detector_core #(
  parameter int WIN_LEN = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_y_i,
  input  logic signed [izvd_pkg::ACCEL_W-1:0] accel_z_i,
  input  logic signed [izvd_pkg::GYRO_W-1:0]  gyro_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                window_full_o,
  output logic                                stationary_o,
  output logic                                zupt_available_o,
  output logic [izvd_pkg::CNT_W-1:0]          still_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [izvd_pkg::PADDR_W-1:0]        paddr,
  input  logic [izvd_pkg::PDATA_W-1:0]        pwdata,
  output logic [izvd_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import izvd_pkg::*;

  cfg_t    cfg_q;
  sample_t push_data;
  sample_t pop_data;
  result_t result;
  logic    push;
  logic    pop;
  logic    fifo_full;
  logic    fifo_empty;
  reg_e    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_norm     <= RST_GRAVITY_NORM;
      cfg_q.accel_dev_limit  <= RST_ACCEL_DEV_LIMIT;
      cfg_q.gyro_rate_limit  <= RST_GYRO_RATE_LIMIT;
      cfg_q.gyro_var_limit   <= RST_GYRO_VAR_LIMIT;
      cfg_q.accel_var_limit  <= RST_ACCEL_VAR_LIMIT;
      cfg_q.available_period <= RST_AVAILABLE_PERIOD;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GRAVITY_NORM:     cfg_q.gravity_norm     <= pwdata[15:0];
        REG_ACCEL_DEV_LIMIT:  cfg_q.accel_dev_limit  <= pwdata[31:0];
        REG_GYRO_RATE_LIMIT:  cfg_q.gyro_rate_limit  <= pwdata[16:0];
        REG_GYRO_VAR_LIMIT:   cfg_q.gyro_var_limit   <= pwdata[33:0];
        REG_ACCEL_VAR_LIMIT:  cfg_q.accel_var_limit  <= pwdata[39:0];
        REG_AVAILABLE_PERIOD: cfg_q.available_period <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRAVITY_NORM:     prdata = PDATA_W'(cfg_q.gravity_norm);
      REG_ACCEL_DEV_LIMIT:  prdata = PDATA_W'(cfg_q.accel_dev_limit);
      REG_GYRO_RATE_LIMIT:  prdata = PDATA_W'(cfg_q.gyro_rate_limit);
      REG_GYRO_VAR_LIMIT:   prdata = PDATA_W'(cfg_q.gyro_var_limit);
      REG_ACCEL_VAR_LIMIT:  prdata = PDATA_W'(cfg_q.accel_var_limit);
      REG_AVAILABLE_PERIOD: prdata = PDATA_W'(cfg_q.available_period);
      default:              prdata = '0;
    endcase
  end

  izvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .gyro_y_i    (gyro_y_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (fifo_full)
  );

  izvd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (fifo_empty)
  );

  izvd_back #(
    .WIN_LEN (WIN_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .sample_i    (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign window_full_o    = result.window_full;
  assign stationary_o     = result.stationary;
  assign zupt_available_o = result.zupt_available;
  assign still_count_o    = result.still_count;

`ifndef SYNTHESIS
  a_stat_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stationary_o |-> window_full_o)
    else $error("stationary result without a full window");

  a_avail_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zupt_available_o |-> still_count_o != '0)
    else $error("availability set with zero still count");

  a_moving_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_full_o && !stationary_o
      |-> still_count_o == '0 && !zupt_available_o)
    else $error("moving sample did not clear count and flag");
`endif

endmodule
